FILE: hw/rtl/suv_pkg.sv
package suv_pkg;

  // default parameter values
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned CORDIC_STEPS_DEF  = 18;

  // fixed field widths
  localparam int unsigned IN_W    = 32;
  localparam int unsigned RAD_W   = 31;
  localparam int unsigned D_W     = 33;   // point minus centre
  localparam int unsigned SQ_W    = 62;   // squares and sqrt radicand
  localparam int unsigned ROOT_W  = 31;
  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned ANG_IN_W = 34;  // CORDIC operand at entry
  localparam int unsigned FOLD_W  = 35;   // operand after half-plane fold
  localparam int unsigned CX_W    = 44;   // CORDIC x/y datapath
  localparam int unsigned Z_W     = 34;   // angle accumulator, turns * 2^32
  localparam int unsigned NORM_RAD = 30;  // radius normalised to [2^30, 2^31)
  localparam int unsigned NORM_VEC = 40;  // CORDIC vector normalised to [2^40, 2^41)
  localparam int unsigned U_W     = 16;
  localparam int unsigned V_W     = 17;

  typedef struct packed {
    logic signed [IN_W-1:0] point_x;
    logic signed [IN_W-1:0] point_y;
    logic signed [IN_W-1:0] point_z;
    logic signed [IN_W-1:0] center_x;
    logic signed [IN_W-1:0] center_y;
    logic signed [IN_W-1:0] center_z;
    logic [RAD_W-1:0]       sphere_radius;
  } in_beat_t;

  // side data that rides along the radicand through the square root
  typedef struct packed {
    logic signed [D_W-1:0]  dx;
    logic signed [D_W-1:0]  dz;
    logic signed [IN_W-1:0] dyn;   // clamped, normalised dy
    logic                   flag;
  } side_t;

  // atan(2^-i) in turns, scaled by 2^32
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // index of the highest set bit, 0 for a zero word
  function automatic logic [5:0] msb_idx(input logic [63:0] v);
    logic [5:0] r;
    r = 6'd0;
    for (int b = 0; b < 64; b++) begin
      if (v[b]) r = 6'(b);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/suv_in_if.sv
interface suv_in_if;
  logic valid;
  logic ready;
  logic signed [suv_pkg::IN_W-1:0] point_x;
  logic signed [suv_pkg::IN_W-1:0] point_y;
  logic signed [suv_pkg::IN_W-1:0] point_z;
  logic signed [suv_pkg::IN_W-1:0] center_x;
  logic signed [suv_pkg::IN_W-1:0] center_y;
  logic signed [suv_pkg::IN_W-1:0] center_z;
  logic [suv_pkg::RAD_W-1:0]       sphere_radius;

  modport source (output valid, point_x, point_y, point_z, center_x, center_y,
                  center_z, sphere_radius, input ready);
  modport sink   (input valid, point_x, point_y, point_z, center_x, center_y,
                  center_z, sphere_radius, output ready);
endinterface

FILE: hw/rtl/suv_out_if.sv
interface suv_out_if;
  logic valid;
  logic ready;
  logic [suv_pkg::U_W-1:0] u_coord;
  logic [suv_pkg::V_W-1:0] v_coord;
  logic                    ratio_clamped;

  modport source (output valid, u_coord, v_coord, ratio_clamped, input ready);
  modport sink   (input valid, u_coord, v_coord, ratio_clamped, output ready);
endinterface

FILE: hw/rtl/spherical_uv_mapping_top.sv
// Spherical UV mapper: one hit point and sphere per beat in, one (u, v, clamp flag)
// beat out, accepting a beat every cycle unless the output stalls. The pipeline has
// four set-up stages for the offsets and R^2 - dy^2, 31 square-root stages, two CORDIC
// (azimuth and polar) running side by side with one micro-rotation per stage, and the
// output register. The whole pipeline advances when the output register is empty or
// taken, so back-pressure freezes every stage.
module spherical_uv_mapping_top #(
  parameter int unsigned FRACTION_BITS = suv_pkg::FRACTION_BITS_DEF,
  parameter int unsigned CORDIC_STEPS  = suv_pkg::CORDIC_STEPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  suv_in_if.sink    item_i,
  suv_out_if.source result_o
);

  localparam int unsigned NS    = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int unsigned A_LAT = NS + 3;
  localparam int unsigned ZW    = suv_pkg::Z_W;
  localparam int unsigned AW    = suv_pkg::ANG_IN_W;
  localparam logic signed [ZW-1:0] HALF = ZW'(64'd2147483648);

  logic adv;
  logic res_vld_q;

  assign adv          = !res_vld_q || result_o.ready;
  assign item_i.ready = adv;

  // input beat
  suv_pkg::in_beat_t beat;
  always_comb begin
    beat.point_x       = item_i.point_x;
    beat.point_y       = item_i.point_y;
    beat.point_z       = item_i.point_z;
    beat.center_x      = item_i.center_x;
    beat.center_y      = item_i.center_y;
    beat.center_z      = item_i.center_z;
    beat.sphere_radius = item_i.sphere_radius;
  end

  logic                           pre_vld, sq_vld;
  logic [suv_pkg::SQ_W-1:0]       pre_rad;
  logic [suv_pkg::ROOT_W-1:0]     sq_root;
  suv_pkg::side_t                 pre_side, sq_side;

  suv_prep u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (item_i.valid),
    .beat_i (beat),
    .vld_o  (pre_vld),
    .rad_o  (pre_rad),
    .side_o (pre_side)
  );

  suv_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (pre_vld),
    .rad_i  (pre_rad),
    .side_i (pre_side),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // azimuth: atan2(dz, dx); polar: atan2(sqrt(R^2 - dy^2), dy)
  logic                  az_vld, pol_vld;
  logic signed [ZW-1:0]  az_ang, pol_ang;
  logic signed [AW-1:0]  az_y, az_x, pol_y, pol_x;

  assign az_y  = AW'(sq_side.dz);
  assign az_x  = AW'(sq_side.dx);
  assign pol_y = $signed({3'b000, sq_root});
  assign pol_x = AW'(sq_side.dyn);

  suv_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_az (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (sq_vld),
    .y_i    (az_y),
    .x_i    (az_x),
    .vld_o  (az_vld),
    .ang_o  (az_ang)
  );

  suv_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_pol (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (sq_vld),
    .y_i    (pol_y),
    .x_i    (pol_x),
    .vld_o  (pol_vld),
    .ang_o  (pol_ang)
  );

  // clamp flag delay matching the CORDIC
  logic [A_LAT-1:0] fl_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fl_q <= {fl_q[A_LAT-2:0], sq_side.flag};
    end
  end

  // u = 0.5 - theta mod 1, v = 2 * phi, both rounded
  logic [31:0]           u_sum, u_w;
  logic signed [ZW-1:0]  ph;
  logic [32:0]           v_sum, v_w;

  always_comb begin
    u_sum = 32'h8000_0000 - az_ang[31:0] + (32'd1 << (31 - FRACTION_BITS));
    u_w   = u_sum >> (32 - FRACTION_BITS);
    ph    = pol_ang;
    if (pol_ang < 0) ph = '0;
    else if (pol_ang > HALF) ph = HALF;
    v_sum = ph[32:0] + (33'd1 << (30 - FRACTION_BITS));
    v_w   = v_sum >> (31 - FRACTION_BITS);
  end

  logic [suv_pkg::U_W-1:0] u_q;
  logic [suv_pkg::V_W-1:0] v_q;
  logic                    flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= pol_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_q    <= u_w[suv_pkg::U_W-1:0];
      v_q    <= v_w[suv_pkg::V_W-1:0];
      flag_q <= fl_q[A_LAT-1];
    end
  end

  assign result_o.valid         = res_vld_q;
  assign result_o.u_coord       = u_q;
  assign result_o.v_coord       = v_q;
  assign result_o.ratio_clamped = flag_q;

`ifndef SYNTHESIS
  // both CORDIC run in lockstep
  a_cordic_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    az_vld == pol_vld) else $error("azimuth and polar CORDIC out of step");

  // a stall freezes the pipeline tail
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(pol_vld)) else $error("pipeline moved during stall");

  // polar coordinate never exceeds one
  a_v_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (32'(result_o.v_coord) <= (32'd1 << FRACTION_BITS)))
    else $error("v_coord above one");
`endif

endmodule

FILE: hw/rtl/suv_prep.sv
// Offsets, clamp, radius normalisation and R^2 - dy^2: four stages.
module suv_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  suv_pkg::in_beat_t beat_i,
  output logic              vld_o,
  output logic [suv_pkg::SQ_W-1:0] rad_o,
  output suv_pkg::side_t    side_o
);

  localparam int unsigned RW = suv_pkg::RAD_W;
  localparam int unsigned DW = suv_pkg::D_W;
  localparam int unsigned IW = suv_pkg::IN_W;
  localparam int unsigned SW = suv_pkg::SQ_W;

  logic [3:0] v_q;

  // stage 1: offsets, zero radius, clamp
  logic signed [DW-1:0] dx_d, dy_d, dz_d, radx;
  logic [RW-1:0]        rad1_d;
  logic signed [DW-1:0] dyc;
  logic                 flag_d;

  logic [RW-1:0]        rad1_q;
  suv_pkg::side_t       s1_q, s2_q, s3_q, s4_q;

  always_comb begin
    dx_d   = $signed({beat_i.point_x[IW-1], beat_i.point_x})
           - $signed({beat_i.center_x[IW-1], beat_i.center_x});
    dy_d   = $signed({beat_i.point_y[IW-1], beat_i.point_y})
           - $signed({beat_i.center_y[IW-1], beat_i.center_y});
    dz_d   = $signed({beat_i.point_z[IW-1], beat_i.point_z})
           - $signed({beat_i.center_z[IW-1], beat_i.center_z});
    rad1_d = (beat_i.sphere_radius == '0) ? RW'(1) : beat_i.sphere_radius;
    radx   = $signed({2'b00, rad1_d});
    flag_d = 1'b0;
    dyc    = dy_d;
    if (dy_d > radx) begin
      dyc    = radx;
      flag_d = 1'b1;
    end else if (dy_d < -radx) begin
      dyc    = -radx;
      flag_d = 1'b1;
    end
  end

  // stage 2: shift radius up to [2^30, 2^31)
  logic [5:0]           msb;
  logic [5:0]           sh;
  logic [RW-1:0]        radn_d;
  logic signed [IW-1:0] dyn_d;
  logic signed [IW-1:0] dyabs;
  logic [RW-1:0]        radn_q, dya_q;

  always_comb begin
    msb    = suv_pkg::msb_idx({33'b0, rad1_q});
    sh     = (msb >= 6'(suv_pkg::NORM_RAD)) ? 6'd0 : 6'(suv_pkg::NORM_RAD) - msb;
    radn_d = rad1_q << sh;
    dyn_d  = s1_q.dyn <<< sh;
    dyabs  = dyn_d[IW-1] ? -dyn_d : dyn_d;
  end

  // stage 3: squares
  logic [SW-1:0] rr_q, yy_q;
  // stage 4: difference
  logic [SW-1:0] n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad1_q     <= rad1_d;
      s1_q.dx    <= dx_d;
      s1_q.dz    <= dz_d;
      s1_q.dyn   <= dyc[IW-1:0];   // clamped, not yet normalised
      s1_q.flag  <= flag_d;

      radn_q     <= radn_d;
      dya_q      <= dyabs[RW-1:0];
      s2_q.dx    <= s1_q.dx;
      s2_q.dz    <= s1_q.dz;
      s2_q.dyn   <= dyn_d;
      s2_q.flag  <= s1_q.flag;

      rr_q       <= SW'(radn_q) * SW'(radn_q);
      yy_q       <= SW'(dya_q) * SW'(dya_q);
      s3_q       <= s2_q;

      n_q        <= rr_q - yy_q;
      s4_q       <= s3_q;
    end
  end

  assign vld_o  = v_q[3];
  assign rad_o  = n_q;
  assign side_o = s4_q;

endmodule

FILE: hw/rtl/suv_isqrt.sv
// Integer square root, one result bit per stage.
module suv_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [suv_pkg::SQ_W-1:0]    rad_i,
  input  suv_pkg::side_t              side_i,
  output logic                        vld_o,
  output logic [suv_pkg::ROOT_W-1:0]  root_o,
  output suv_pkg::side_t              side_o
);

  localparam int unsigned SW = suv_pkg::SQ_W;
  localparam int unsigned NS = suv_pkg::SQRT_STEPS;

  logic [SW-1:0]  n_q [NS];
  logic [SW-1:0]  r_q [NS];
  suv_pkg::side_t s_q [NS];
  logic [NS-1:0]  v_q;

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic [SW-1:0]  n_in, r_in, bitv, trial;
    logic           v_in;
    suv_pkg::side_t s_in;

    if (k == 0) begin : g_first
      assign n_in = rad_i;
      assign r_in = '0;
      assign v_in = vld_i;
      assign s_in = side_i;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
      assign v_in = v_q[k-1];
      assign s_in = s_q[k-1];
    end

    assign bitv  = SW'(1) << (2 * (NS - 1 - k));
    assign trial = r_in + bitv;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    // restoring step: subtract the trial value when it fits
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k] <= s_in;
        if (n_in >= trial) begin
          n_q[k] <= n_in - trial;
          r_q[k] <= (r_in >> 1) + bitv;
        end else begin
          n_q[k] <= n_in;
          r_q[k] <= r_in >> 1;
        end
      end
    end
  end

  assign vld_o  = v_q[NS-1];
  assign root_o = r_q[NS-1][suv_pkg::ROOT_W-1:0];
  assign side_o = s_q[NS-1];

endmodule

FILE: hw/rtl/suv_atan2.sv
// atan2(y, x) in turns * 2^32: fold, normalise, then one CORDIC rotation per stage.
module suv_atan2 #(
  parameter int unsigned STEPS = suv_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic signed [suv_pkg::ANG_IN_W-1:0] y_i,
  input  logic signed [suv_pkg::ANG_IN_W-1:0] x_i,
  output logic                              vld_o,
  output logic signed [suv_pkg::Z_W-1:0]    ang_o
);

  localparam int unsigned NS = (STEPS > 32) ? 32 : STEPS;
  localparam int unsigned AW = suv_pkg::ANG_IN_W;
  localparam int unsigned FW = suv_pkg::FOLD_W;
  localparam int unsigned CW = suv_pkg::CX_W;
  localparam int unsigned ZW = suv_pkg::Z_W;
  localparam logic signed [ZW-1:0] HALF = ZW'(64'd2147483648);

  // stage A: fold the left half-plane onto the right
  logic                 neg, zero_d;
  logic signed [FW-1:0] xf_d, yf_d, ay;
  logic [FW-1:0]        m_d;
  logic signed [ZW-1:0] base_d;

  always_comb begin
    neg    = x_i[AW-1];
    zero_d = (x_i == '0) && (y_i == '0);
    xf_d   = neg ? -$signed({x_i[AW-1], x_i}) : $signed({x_i[AW-1], x_i});
    yf_d   = neg ? -$signed({y_i[AW-1], y_i}) : $signed({y_i[AW-1], y_i});
    ay     = yf_d[FW-1] ? -yf_d : yf_d;
    m_d    = (xf_d > ay) ? xf_d : ay;
    base_d = '0;
    if (neg) base_d = y_i[AW-1] ? -HALF : HALF;
  end

  logic                 va_q, vb_q;
  logic signed [FW-1:0] xa_q, ya_q;
  logic [FW-1:0]        ma_q;
  logic signed [ZW-1:0] basea_q, baseb_q;
  logic                 zeroa_q, zerob_q;

  // stage B: normalise the larger component to [2^40, 2^41)
  logic [5:0]           msb, sh;
  logic signed [CW-1:0] xb_d, yb_d, xb_q, yb_q;

  always_comb begin
    msb  = suv_pkg::msb_idx({29'b0, ma_q});
    sh   = 6'(suv_pkg::NORM_VEC) - msb;
    xb_d = CW'(xa_q) <<< sh;
    yb_d = CW'(ya_q) <<< sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= vld_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q    <= xf_d;
      ya_q    <= yf_d;
      ma_q    <= m_d;
      basea_q <= base_d;
      zeroa_q <= zero_d;
      xb_q    <= xb_d;
      yb_q    <= yb_d;
      baseb_q <= basea_q;
      zerob_q <= zeroa_q;
    end
  end

  // CORDIC rotations
  logic signed [CW-1:0] cx_q [NS];
  logic signed [CW-1:0] cy_q [NS];
  logic signed [ZW-1:0] cz_q [NS];
  logic signed [ZW-1:0] cb_q [NS];
  logic [NS-1:0]        cz0_q;
  logic [NS-1:0]        cv_q;

  for (genvar i = 0; i < NS; i++) begin : g_rot
    logic signed [CW-1:0] x_in, y_in, xs, ys;
    logic signed [ZW-1:0] z_in, b_in, at;
    logic                 v_in, z0_in;

    if (i == 0) begin : g_first
      assign x_in  = xb_q;
      assign y_in  = yb_q;
      assign z_in  = '0;
      assign b_in  = baseb_q;
      assign z0_in = zerob_q;
      assign v_in  = vb_q;
    end else begin : g_next
      assign x_in  = cx_q[i-1];
      assign y_in  = cy_q[i-1];
      assign z_in  = cz_q[i-1];
      assign b_in  = cb_q[i-1];
      assign z0_in = cz0_q[i-1];
      assign v_in  = cv_q[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;
    assign at = $signed({2'b00, suv_pkg::atan_turn(5'(i))});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i] <= 1'b0;
      end else if (en_i) begin
        cv_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cb_q[i]  <= b_in;
        cz0_q[i] <= z0_in;
        if (y_in > 0) begin
          cx_q[i] <= x_in + ys;
          cy_q[i] <= y_in - xs;
          cz_q[i] <= z_in + at;
        end else begin
          cx_q[i] <= x_in - ys;
          cy_q[i] <= y_in + xs;
          cz_q[i] <= z_in - at;
        end
      end
    end
  end

  // final: add the half-turn base, zero vector gives zero
  logic                 vo_q;
  logic signed [ZW-1:0] ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= cv_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= cz0_q[NS-1] ? '0 : cb_q[NS-1] + cz_q[NS-1];
    end
  end

  assign vld_o = vo_q;
  assign ang_o = ang_q;

endmodule

FILE: sim/tb.sv
module tb;

  localparam int unsigned STEPS    = suv_pkg::CORDIC_STEPS_DEF;
  localparam int unsigned FRAC     = suv_pkg::FRACTION_BITS_DEF;
  localparam int unsigned RW       = suv_pkg::RAD_W;
  localparam int          N_RANDOM = 930;
  localparam int          LIMIT    = 400000;

  typedef struct packed {
    logic [suv_pkg::U_W-1:0] u_coord;
    logic [suv_pkg::V_W-1:0] v_coord;
    logic                    ratio_clamped;
  } uv_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  suv_in_if  in_bus ();
  suv_out_if out_bus ();

  spherical_uv_mapping_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_bus),
    .result_o (out_bus)
  );

  always #5 clk_i = ~clk_i;

  suv_pkg::in_beat_t pending_hits[$];
  uv_t      expected_uv[$];
  int       n_fail = 0;
  int       n_checked = 0;
  int       n_clamped = 0;
  int       n_sent = 0;
  int       cycle_cnt = 0;
  bit       calm = 1'b0;  // stretch with no idling on either side

  // atan(2^-i) in turns scaled by 2^32
  longint atan_lut[32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  function automatic longint floor_shr(longint a, int s);
    return a >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // vectoring CORDIC, angle in turns * 2^32
  function automatic longint angle_turns(longint y, longint x);
    longint base, z, m, xs, ys, ay;
    base = 0;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      base = (y >= 0) ? 64'sh80000000 : -64'sh80000000;
      x = -x;
      y = -y;
    end
    ay = (y < 0) ? -y : y;
    m = (x > ay) ? x : ay;
    while (m < (64'sd1 << 40)) begin
      m *= 2; x *= 2; y *= 2;
    end
    for (int i = 0; i < STEPS && i < 32; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += atan_lut[i];
      end else begin
        x -= ys; y += xs; z -= atan_lut[i];
      end
    end
    return base + z;
  endfunction

  // texture coordinates of one hit
  function automatic uv_t map_hit(suv_pkg::in_beat_t h);
    longint dx, dy, dz, rad, th, ph;
    longint unsigned uu, vv, rt;
    uv_t r;
    dx  = longint'(h.point_x) - longint'(h.center_x);
    dy  = longint'(h.point_y) - longint'(h.center_y);
    dz  = longint'(h.point_z) - longint'(h.center_z);
    rad = longint'({1'b0, h.sphere_radius});
    r.ratio_clamped = 1'b0;
    th = angle_turns(dz, dx);
    uu = (longint'(64'sh80000000) - th) + (64'd1 << (31 - FRAC));
    uu = uu >> (32 - FRAC);
    if (rad == 0) rad = 1;
    if (dy > rad) begin
      dy = rad; r.ratio_clamped = 1'b1;
    end else if (dy < -rad) begin
      dy = -rad; r.ratio_clamped = 1'b1;
    end
    while (rad < (64'sd1 << 30)) begin
      rad *= 2; dy *= 2;
    end
    rt = int_sqrt(longint'(rad * rad) - longint'(dy * dy));
    ph = angle_turns(longint'(rt), dy);
    if (ph < 0) ph = 0;
    if (ph > 64'sh80000000) ph = 64'sh80000000;
    vv = (longint'(ph) + (64'd1 << (30 - FRAC))) >> (31 - FRAC);
    r.u_coord = uu[suv_pkg::U_W-1:0];
    r.v_coord = vv[suv_pkg::V_W-1:0];
    return r;
  endfunction

  function automatic int draw_wait();
    if (calm) return 0;
    return (($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 2));
  endfunction

  function automatic suv_pkg::in_beat_t make_hit(int px, int py, int pz,
                                                 int cx, int cy, int cz,
                                                 logic [suv_pkg::RAD_W-1:0] r);
    suv_pkg::in_beat_t h;
    h.point_x = px; h.point_y = py; h.point_z = pz;
    h.center_x = cx; h.center_y = cy; h.center_z = cz;
    h.sphere_radius = r;
    return h;
  endfunction

  // hit near the surface of a random sphere
  function automatic suv_pkg::in_beat_t surface_hit();
    int r, cx, cy, cz, dx, dy, dz, span;
    r    = $urandom_range(1, 1 << $urandom_range(0, 28));
    span = r + r / 8 + 1;
    cx = $urandom_range(0, 1 << 29) - (1 << 28);
    cy = $urandom_range(0, 1 << 29) - (1 << 28);
    cz = $urandom_range(0, 1 << 29) - (1 << 28);
    dx = $urandom_range(0, 2 * span) - span;
    dy = $urandom_range(0, 2 * span) - span;
    dz = $urandom_range(0, 2 * span) - span;
    case ($urandom_range(0, 9))
      0: begin dx = 0; dz = 0; end
      1: dy = ($urandom_range(0, 1)) ? r : -r;
      default: ;
    endcase
    return make_hit(cx + dx, cy + dy, cz + dz, cx, cy, cz, RW'(r));
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    suv_pkg::in_beat_t h;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_gap = 0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (in_bus.valid) n_sent++;
      if (in_gap > 0) begin
        in_gap--;
        in_bus.valid <= 1'b0;
      end else if (pending_hits.size() > 0) begin
        h = pending_hits.pop_front();
        in_bus.point_x       <= h.point_x;
        in_bus.point_y       <= h.point_y;
        in_bus.point_z       <= h.point_z;
        in_bus.center_x      <= h.center_x;
        in_bus.center_y      <= h.center_y;
        in_bus.center_z      <= h.center_z;
        in_bus.sphere_radius <= h.sphere_radius;
        in_bus.valid         <= 1'b1;
        expected_uv.push_back(map_hit(h));
        in_gap = draw_wait();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // monitor: back-pressure and checking
  int out_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    uv_t e;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        n_checked++;
        if (expected_uv.size() == 0) begin
          $error("result beat with nothing expected");
          n_fail++;
        end else begin
          e = expected_uv.pop_front();
          if (out_bus.ratio_clamped) n_clamped++;
          if (out_bus.u_coord !== e.u_coord) begin
            $error("u_coord: expected %0d, got %0d", e.u_coord, out_bus.u_coord);
            n_fail++;
          end
          if (out_bus.v_coord !== e.v_coord) begin
            $error("v_coord: expected %0d, got %0d", e.v_coord, out_bus.v_coord);
            n_fail++;
          end
          if (out_bus.ratio_clamped !== e.ratio_clamped) begin
            $error("ratio_clamped: expected %0d, got %0d", e.ratio_clamped,
                   out_bus.ratio_clamped);
            n_fail++;
          end
        end
        out_stall = draw_wait();
        out_bus.ready <= (out_stall == 0);
      end else if (out_stall > 0) begin
        out_stall--;
        out_bus.ready <= (out_stall == 0);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    suv_pkg::in_beat_t h;
    in_bus.valid = 1'b0;
    in_bus.point_x = '0; in_bus.point_y = '0; in_bus.point_z = '0;
    in_bus.center_x = '0; in_bus.center_y = '0; in_bus.center_z = '0;
    in_bus.sphere_radius = '0;
    out_bus.ready = 1'b0;

    // directed corners
    pending_hits.push_back(make_hit(0, 0, 0, 0, 0, 0, 31'h10000));          // zero offset
    pending_hits.push_back(make_hit(5, 7, 5, 5, 0, 5, 31'd7));              // dy == radius
    pending_hits.push_back(make_hit(5, -7, 5, 5, 0, 5, 31'd7));             // dy == -radius
    pending_hits.push_back(make_hit(0, 8, 0, 0, 0, 0, 31'd7));              // just clamped
    pending_hits.push_back(make_hit(1, 0, 0, 0, 0, 0, 31'd0));              // zero radius
    pending_hits.push_back(make_hit(1, 3, 0, 0, 0, 0, 31'd0));
    pending_hits.push_back(make_hit(-65536, 0, -1, 0, 0, 0, 31'h10000));    // angle near -pi
    pending_hits.push_back(make_hit(-65536, 0, 1, 0, 0, 0, 31'h10000));     // angle near pi
    pending_hits.push_back(make_hit(-65536, 0, 0, 0, 0, 0, 31'h10000));
    pending_hits.push_back(make_hit(0, 0, 65536, 0, 0, 0, 31'h10000));
    pending_hits.push_back(make_hit(0, 0, -65536, 0, 0, 0, 31'h10000));
    pending_hits.push_back(make_hit(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                    32'h80000000, 32'h80000000, 32'h80000000,
                                    31'h7fffffff));
    pending_hits.push_back(make_hit(32'h80000000, 32'h80000000, 32'h80000000,
                                    32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                    31'h7fffffff));
    pending_hits.push_back(make_hit(32'h7fffffff, 32'h80000000, 0,
                                    32'h80000000, 32'h7fffffff, 0, 31'd1));
    pending_hits.push_back(make_hit(-1, -1, -1, 0, 0, 0, 31'h7fffffff));
    pending_hits.push_back(make_hit(3, 0, 4, 0, 0, 0, 31'd5));
    pending_hits.push_back(make_hit(0, 32'h7fffffff, 0, 0, 0, 0, 31'h7fffffff));
    pending_hits.push_back(make_hit(0, 32'h80000001, 0, 0, 0, 0, 31'h7fffffff));
    pending_hits.push_back(make_hit(100, -50, 0, 0, 0, 0, 31'd200));

    // random: mostly hits near a sphere, the rest arbitrary words
    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 9) < 7) begin
        h = surface_hit();
      end else begin
        h = make_hit($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     RW'($urandom));
      end
      pending_hits.push_back(h);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // toggle idle-free stretches while the stimulus drains
    while (pending_hits.size() > 0 || expected_uv.size() > 0) begin
      @(posedge clk_i);
      if ($urandom_range(0, 199) == 0) calm = ~calm;
    end
    repeat (80) @(posedge clk_i);

    $display("%0d hits sent, %0d results checked, %0d with the ratio clamped",
             n_sent, n_checked, n_clamped);
    if (n_fail == 0 && expected_uv.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/suv_pkg.sv
hw/rtl/suv_in_if.sv
hw/rtl/suv_out_if.sv
hw/rtl/suv_prep.sv
hw/rtl/suv_isqrt.sv
hw/rtl/suv_atan2.sv
hw/rtl/spherical_uv_mapping_top.sv
sim/tb.sv
